// ===== rtl/sms_nfp_pkg.sv =====
package sms_nfp_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    localparam logic [3:0] ST_WAIT_NUM   = 4'd0;
    localparam logic [3:0] ST_NUM        = 4'd1;
    localparam logic [3:0] ST_WAIT_ALPHA = 4'd2;
    localparam logic [3:0] ST_ALPHA      = 4'd3;
    localparam logic [3:0] ST_WAIT_DT    = 4'd4;
    localparam logic [3:0] ST_DT         = 4'd5;
    localparam logic [3:0] ST_WAIT_DATA  = 4'd6;
    localparam logic [3:0] ST_WAIT_DATA2 = 4'd7;
    localparam logic [3:0] ST_DATA       = 4'd8;

    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [7:0] position;
        logic [3:0] number_length;
        logic [7:0] body_length;
        logic       last;
    } t_result;

endpackage

// ===== rtl/sms_notification_field_parser.sv =====
// a result item is registered in the result queue when the input item that yields it is accepted
// throughput: one input item per cycle while the queue has room; an item that yields two
// results (final byte with a stored character) writes both into a four-entry result queue
// the input is held off only while the queue lacks room for two results
// reset (i_rst_n low, synchronous): parser back to waiting for number, counts and
// held bytes cleared, result queue emptied
module sms_notification_field_parser
    import sms_nfp_pkg::*;
#(
    parameter int NUMBER_MAX = 12,
    parameter int BODY_MAX   = 160
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] char_value, [15:8] position,
                                     // [19:16] number_length, [27:20] body_length
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last
);

    localparam int QDEPTH = 4;

    logic [3:0] r_stage, n_stage;
    logic [7:0] r_idx, n_idx;
    logic [3:0] r_ncnt, n_ncnt;
    logic [7:0] r_bcnt, n_bcnt;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_hvalid, n_hvalid;

    t_result    r_q [QDEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    logic       accept, pop;
    logic       char_ok;
    logic [1:0] char_kind;
    t_result    char_res, done_res, wr0, wr1;
    logic [1:0] n_wr;

    assign o_s_tready = (r_cnt <= 3'(QDEPTH - 2));
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign pop        = o_m_tvalid && i_m_tready;

    always_comb begin
        n_stage   = r_stage;
        n_idx     = r_idx;
        n_ncnt    = r_ncnt;
        n_bcnt    = r_bcnt;
        n_held0   = r_held0;
        n_held1   = r_held1;
        n_hvalid  = r_hvalid;
        char_ok   = 1'b0;
        char_kind = KIND_NUMBER;

        // the oldest held byte is parsed only once two bytes are held
        if (r_hvalid == 2'd2) begin
            if (r_held0 == CH_QUOTE) begin
                if (r_stage == ST_WAIT_NUM || r_stage == ST_WAIT_ALPHA ||
                    r_stage == ST_WAIT_DT) begin
                    n_stage = r_stage + 4'd1;
                    n_idx   = 8'd0;
                end else if (r_stage == ST_NUM || r_stage == ST_ALPHA ||
                             r_stage == ST_DT) begin
                    n_stage = r_stage + 4'd1;
                end
            end else if (r_held0 == CH_CR && r_stage != ST_DATA) begin
                if (r_stage == ST_WAIT_DATA) begin
                    n_stage = ST_WAIT_DATA2;
                end
            end else if (r_held0 == CH_LF && r_stage != ST_DATA) begin
                if (r_stage == ST_WAIT_DATA2) begin
                    n_stage = ST_DATA;
                    n_idx   = 8'd0;
                end
            end else if (r_stage == ST_NUM && r_idx < 8'(NUMBER_MAX)) begin
                char_ok   = 1'b1;
                char_kind = KIND_NUMBER;
                n_idx     = r_idx + 8'd1;
                n_ncnt    = n_idx[3:0];
            end else if (r_stage == ST_DATA && r_idx < 8'(BODY_MAX)) begin
                char_ok   = 1'b1;
                char_kind = KIND_BODY;
                n_idx     = r_idx + 8'd1;
                n_bcnt    = n_idx;
            end
            n_held0 = r_held1;
            n_held1 = i_s_tdata;
        end else if (r_hvalid == 2'd1) begin
            n_held1  = i_s_tdata;
            n_hvalid = 2'd2;
        end else begin
            n_held0  = i_s_tdata;
            n_hvalid = 2'd1;
        end

        char_res.kind          = char_kind;
        char_res.char_value    = r_held0;
        char_res.position      = r_idx;
        char_res.number_length = 4'd0;
        char_res.body_length   = 8'd0;
        char_res.last          = !i_s_tlast;

        done_res.kind          = KIND_DONE;
        done_res.char_value    = 8'd0;
        done_res.position      = 8'd0;
        done_res.number_length = n_ncnt;
        done_res.body_length   = n_bcnt;
        done_res.last          = 1'b1;

        wr0  = char_ok ? char_res : done_res;
        wr1  = done_res;
        n_wr = {1'b0, char_ok} + {1'b0, i_s_tlast};

        // final byte: back to the reset state for the next frame
        if (i_s_tlast) begin
            n_stage  = ST_WAIT_NUM;
            n_idx    = 8'd0;
            n_ncnt   = 4'd0;
            n_bcnt   = 8'd0;
            n_held0  = 8'd0;
            n_held1  = 8'd0;
            n_hvalid = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= ST_WAIT_NUM;
            r_idx    <= 8'd0;
            r_ncnt   <= 4'd0;
            r_bcnt   <= 8'd0;
            r_held0  <= 8'd0;
            r_held1  <= 8'd0;
            r_hvalid <= 2'd0;
        end else if (accept) begin
            r_stage  <= n_stage;
            r_idx    <= n_idx;
            r_ncnt   <= n_ncnt;
            r_bcnt   <= n_bcnt;
            r_held0  <= n_held0;
            r_held1  <= n_held1;
            r_hvalid <= n_hvalid;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (accept && n_wr != 2'd0) begin
            r_q[r_wp] <= wr0;
        end
        if (accept && n_wr == 2'd2) begin
            r_q[r_wp + 2'd1] <= wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + n_wr;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + (accept ? {1'b0, n_wr} : 3'd0) - {2'b00, pop};
        end
    end

    assign o_m_tuser = r_q[r_rp].kind;
    assign o_m_tlast = r_q[r_rp].last;
    assign o_m_tdata = {4'd0, r_q[r_rp].body_length, r_q[r_rp].number_length,
                        r_q[r_rp].position, r_q[r_rp].char_value};

endmodule

// ===== bench/sms_notification_field_parser_tb.sv =====
module sms_notification_field_parser_tb;
    import sms_nfp_pkg::*;

    localparam int NUMBER_LIMIT = 12;
    localparam int BODY_LIMIT   = 160;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MISMATCH_SHOWN = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;   // [7:0] data_byte
    logic        i_s_tlast = 1'b0;   // end_of_message
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;          // [7:0] char_value, [15:8] position,
                                     // [19:16] number_length, [27:20] body_length
    logic [1:0]  o_m_tuser;          // [1:0] kind
    logic        o_m_tlast;          // last

    sms_notification_field_parser #(
        .NUMBER_MAX(NUMBER_LIMIT),
        .BODY_MAX  (BODY_LIMIT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser copy kept by the bench
    logic [3:0] nf_stage;
    logic [7:0] nf_index;
    logic [3:0] nf_number_len;
    logic [7:0] nf_body_len;
    logic [7:0] nf_held [2];
    logic [1:0] nf_held_cnt;

    t_result field_results_q [$];

    int tx_idle_pct = 29;
    int rx_idle_pct = 50;
    int items_sent  = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    function automatic void clear_parser();
        nf_stage      = ST_WAIT_NUM;
        nf_index      = 8'd0;
        nf_number_len = 4'd0;
        nf_body_len   = 8'd0;
        nf_held[0]    = 8'd0;
        nf_held[1]    = 8'd0;
        nf_held_cnt   = 2'd0;
    endfunction

    // walks one released byte through the field stages
    function automatic void parse_field_byte(input logic [7:0] b, output bit hit,
                                             output t_result r);
        hit = 1'b0;
        r   = '0;
        if (b == CH_QUOTE) begin
            if (nf_stage == ST_WAIT_NUM || nf_stage == ST_WAIT_ALPHA ||
                nf_stage == ST_WAIT_DT) begin
                nf_stage = nf_stage + 4'd1;
                nf_index = 8'd0;
            end else if (nf_stage == ST_NUM || nf_stage == ST_ALPHA || nf_stage == ST_DT) begin
                nf_stage = nf_stage + 4'd1;
            end
        end else if (b == CH_CR && nf_stage != ST_DATA) begin
            if (nf_stage == ST_WAIT_DATA)
                nf_stage = ST_WAIT_DATA2;
        end else if (b == CH_LF && nf_stage != ST_DATA) begin
            if (nf_stage == ST_WAIT_DATA2) begin
                nf_stage = ST_DATA;
                nf_index = 8'd0;
            end
        end else if (nf_stage == ST_NUM && nf_index < NUMBER_LIMIT) begin
            hit = 1'b1;
            r.kind = KIND_NUMBER;
            r.char_value = b;
            r.position = nf_index;
            nf_index = nf_index + 8'd1;
            nf_number_len = nf_index[3:0];
        end else if (nf_stage == ST_DATA && nf_index < BODY_LIMIT) begin
            hit = 1'b1;
            r.kind = KIND_BODY;
            r.char_value = b;
            r.position = nf_index;
            nf_index = nf_index + 8'd1;
            nf_body_len = nf_index;
        end
    endfunction

    function automatic void parse_notification_byte(input logic [7:0] b, input logic eom);
        t_result r;
        t_result done_r;
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (nf_held_cnt >= 2'd2) begin
            parse_field_byte(nf_held[0], hit, r);
            nf_held[0] = nf_held[1];
            nf_held[1] = b;
        end else begin
            nf_held[nf_held_cnt[0]] = b;
            nf_held_cnt = nf_held_cnt + 2'd1;
        end
        if (eom) begin
            if (hit)
                field_results_q.push_back(r);
            done_r = '0;
            done_r.kind = KIND_DONE;
            done_r.number_length = nf_number_len;
            done_r.body_length = nf_body_len;
            done_r.last = 1'b1;
            field_results_q.push_back(done_r);
            clear_parser();
        end else if (hit) begin
            r.last = 1'b1;
            field_results_q.push_back(r);
        end
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result seen,
                                 input logic [3:0] pad);
        if (mismatches < MISMATCH_SHOWN)
            $display({"mismatch (%s): expected kind %0d char %02h pos %0d nlen %0d",
                      " blen %0d last %0d, got kind %0d char %02h pos %0d nlen %0d",
                      " blen %0d last %0d pad %h"},
                     what, want.kind, want.char_value, want.position, want.number_length,
                     want.body_length, want.last, seen.kind, seen.char_value, seen.position,
                     seen.number_length, seen.body_length, seen.last, pad);
        mismatches++;
    endtask

    initial clear_parser();

    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                seen.kind = o_m_tuser;
                seen.char_value = o_m_tdata[7:0];
                seen.position = o_m_tdata[15:8];
                seen.number_length = o_m_tdata[19:16];
                seen.body_length = o_m_tdata[27:20];
                seen.last = o_m_tlast;
                if (field_results_q.size() == 0) begin
                    note_mismatch("unexpected item", '0, seen, o_m_tdata[31:28]);
                end else begin
                    want = field_results_q.pop_front();
                    if (seen != want || o_m_tdata[31:28] != 4'd0)
                        note_mismatch("field", want, seen, o_m_tdata[31:28]);
                end
            end
            if (i_s_tvalid && o_s_tready)
                parse_notification_byte(i_s_tdata, i_s_tlast);
        end
    end

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sms_notification_field_parser_tb failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eom;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] fr [$]);
        foreach (fr[i])
            send_item(fr[i], i == fr.size() - 1);
    endtask

    function automatic void add_text(ref logic [7:0] fr [$], input int n, input bit allow_quote);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (!allow_quote && b == CH_QUOTE)
                b = 8'h35;
            fr.push_back(b);
        end
    endfunction

    task automatic test_short_frames();
        send_item(8'hFF, 1'b1);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b1);
    endtask

    // extreme bytes in both fields, quote and cr lf inside the body, char plus done at the end
    task automatic test_field_extremes();
        logic [7:0] fr [$];
        fr = '{CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_QUOTE,
               CH_CR, CH_LF, 8'hFF, 8'h00, CH_QUOTE, CH_CR, CH_LF, 8'h41, 8'h42};
        send_frame(fr);
    endtask

    task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_items);
        logic [7:0] fr [$];
        int target;
        int pick;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            fr.delete();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                add_text(fr, $urandom_range(1, 20), 1'b1);
            end else begin
                add_text(fr, $urandom_range(0, 6), 1'b0);
                fr.push_back(CH_QUOTE);
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 15);
                add_text(fr, len, 1'b0);
                fr.push_back(CH_QUOTE);
                fr.push_back(8'h2C);
                fr.push_back(CH_QUOTE);
                add_text(fr, $urandom_range(0, 5), 1'b0);
                fr.push_back(CH_QUOTE);
                fr.push_back(8'h2C);
                fr.push_back(CH_QUOTE);
                add_text(fr, $urandom_range(0, 20), 1'b0);
                fr.push_back(CH_QUOTE);
                fr.push_back(CH_CR);
                fr.push_back(CH_LF);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 200) : $urandom_range(0, 30);
                add_text(fr, len, 1'b1);
                if ($urandom_range(0, 1)) begin
                    fr.push_back(CH_CR);
                    fr.push_back(CH_LF);
                end else begin
                    add_text(fr, 2, 1'b1);
                end
                // broken frames: cut short or a stray quote
                if (pick >= 85) begin
                    if ($urandom_range(0, 1))
                        fr = fr[0:$urandom_range(0, fr.size() - 1)];
                    else
                        fr.insert($urandom_range(0, fr.size() - 1), CH_QUOTE);
                end
            end
            send_frame(fr);
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_field_extremes();
        test_random_frames(29, 50, 270);
        test_random_frames(50, 29, 270);
        test_random_frames(0, 0, 270);

        while (field_results_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && field_results_q.size() == 0)
            $display("sms_notification_field_parser_tb passed");
        else
            $display("sms_notification_field_parser_tb failed");
        $finish;
    end

endmodule

// ===== sms_notification_field_parser.f =====
rtl/sms_nfp_pkg.sv
rtl/sms_notification_field_parser.sv
bench/sms_notification_field_parser_tb.sv
